FILE: hdl/gcmi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gcmi_pkg;

    // Fixed field widths
    localparam int IDX_W    = 12;
    localparam int GRID_W   = 7;
    localparam int LVL_W    = 6;
    localparam int HGT_W    = 16;
    localparam int COST_W   = 13;

    // Cost arithmetic
    localparam int COST_SCALE = 100;
    localparam int RING_STEP  = 2;
    localparam int MIN_RING   = 4;

    // Input modes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    // Reply kinds
    localparam logic REPLY_DONE = 1'b0;
    localparam logic REPLY_READ = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_OCOST = 2'd2;
    localparam logic [1:0] REG_HLIM  = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_EV,
        ST_H_CRD,
        ST_H_CEV,
        ST_H_NB,
        ST_H_NEV,
        ST_S_SRD,
        ST_S_SGET,
        ST_S_DIV,
        ST_S_LEV,
        ST_F_FRD,
        ST_F_FGET,
        ST_F_NB,
        ST_F_NRD,
        ST_F_NEV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OFF_NEG,
        OFF_ZERO,
        OFF_POS
    } t_off;

    // Per-field write enables of the cell store
    typedef struct packed {
        logic pas;
        logic hgt;
        logic lvl;
    } t_cell_we;

    // 8-neighbourhood in row-major order, center skipped
    function automatic t_off nb_row_off(input logic [3:0] k);
        t_off o;
        case (k)
            4'd0, 4'd1, 4'd2: o = OFF_NEG;
            4'd3, 4'd4:       o = OFF_ZERO;
            default:          o = OFF_POS;
        endcase
        return o;
    endfunction

    function automatic t_off nb_col_off(input logic [3:0] k);
        t_off o;
        case (k)
            4'd0, 4'd3, 4'd5: o = OFF_NEG;
            4'd1, 4'd6:       o = OFF_ZERO;
            default:          o = OFF_POS;
        endcase
        return o;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/grid_cost_map_inflation.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    i_mode i_cell_index i_obstacle_hit
//                                                 i_floor_hit i_height
// output    out        o_out_valid / i_out_stall  o_reply_kind o_passable o_extra_cost
// config    in         psel penable pwrite pready paddr pwdata prdata
//
// A load word is written straight from idle; a read word reads the cell store, then fills its output slot.
// A run word walks the grid: each passable cell is read, then its in-bounds neighbours, and after
// that each seed's row comes from a divide by repeated subtraction before its rings are flooded; the
// single read port of the cell store makes all these reads take turns.
// Reset is synchronous and active low; it clears control and the seed queue count.
// Input stalls whenever a word is in work; a stalled output holds the sequencer.
module grid_cost_map_inflation
    import gcmi_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [1:0]              i_mode,
    input  wire logic [IDX_W-1:0]        i_cell_index,
    input  wire logic                    i_obstacle_hit,
    input  wire logic                    i_floor_hit,
    input  wire logic signed [HGT_W-1:0] i_height,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic                         o_reply_kind,
    output logic                         o_passable,
    output logic [COST_W-1:0]            o_extra_cost,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int CLW   = $clog2(MAX_COLS + 1);
    localparam int FW    = RW + CLW;
    localparam int XW    = (CNTW > IDX_W) ? CNTW : IDX_W;
    localparam int GRW   = (RW > GRID_W) ? RW : GRID_W;
    localparam int GCW   = (CLW > GRID_W) ? CLW : GRID_W;

    // Configuration registers
    logic [GRID_W-1:0] r_grid_rows, r_grid_cols;
    logic [GRID_W-1:0] n_grid_rows, n_grid_cols;
    logic [LVL_W-1:0]  r_ocost;
    logic [15:0]       r_hlim;

    // Effective grid size
    logic [RW-1:0]   r_rows;
    logic [CLW-1:0]  r_cols;
    logic [CNTW-1:0] r_ncells;
    logic [RW-1:0]   rows_eff;
    logic [CLW-1:0]  cols_eff;

    // Sequencer state
    t_state          r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [CNTW-1:0] r_s, n_s;
    logic [CNTW-1:0] r_hidx, n_hidx;
    logic [RW-1:0]   r_hr, n_hr;
    logic [CLW-1:0]  r_hc, n_hc;
    logic [3:0]      r_k, n_k;
    logic [HGT_W-1:0] r_h0, n_h0;
    logic [AW-1:0]   r_seed, n_seed;
    logic [CNTW-1:0] r_rem, n_rem;
    logic [RW-1:0]   r_fr, n_fr;
    logic [CLW-1:0]  r_fc, n_fc;
    logic [RW-1:0]   r_nr, n_nr;
    logic [CLW-1:0]  r_nc, n_nc;
    logic [AW-1:0]   r_naddr, n_naddr;
    logic [LVL_W-1:0] r_lvl, n_lvl;
    logic [CNTW-1:0] r_now, n_now;
    logic [CNTW-1:0] r_nxt, n_nxt;
    logic [CNTW-1:0] r_i, n_i;
    logic            r_cur, n_cur;
    logic            r_oob, n_oob;

    // Output slot
    logic              r_ovalid, n_ovalid;
    logic              r_okind, n_okind;
    logic              r_opas, n_opas;
    logic [COST_W-1:0] r_ocost_out, n_ocost_out;

    // Cell store ports
    t_cell_we         cm_we;
    logic [AW-1:0]    cm_waddr;
    logic             cm_wpas;
    logic [HGT_W-1:0] cm_whgt;
    logic [LVL_W-1:0] cm_wlvl;
    logic             cm_re;
    logic [AW-1:0]    cm_raddr;
    logic             cm_rpas;
    logic [HGT_W-1:0] cm_rhgt;
    logic [LVL_W-1:0] cm_rlvl;

    // Seed queue and frontier memories
    logic [AW-1:0] seed_mem [CELLS];
    logic          sq_we, sq_re;
    logic [AW-1:0] sq_waddr, sq_wdata, sq_raddr, sq_rdata;

    logic [FW-1:0] front_mem [2*CELLS];
    logic          fq_we, fq_re;
    logic [AW:0]   fq_waddr, fq_raddr;
    logic [FW-1:0] fq_wdata, fq_rdata;

    logic            in_acc, out_free, cfg_wr, idx_ok;
    logic [CNTW-1:0] cols_x;
    logic signed [HGT_W:0] hdiff;
    logic [LVL_W-1:0] base_lvl;
    t_off            ro, co;
    logic            nb_ok;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign idx_ok   = XW'(i_cell_index) < XW'(r_ncells);
    assign cols_x   = CNTW'(r_cols);
    assign hdiff    = $signed({cm_rhgt[HGT_W-1], cm_rhgt}) - $signed({r_h0[HGT_W-1], r_h0});
    assign base_lvl = (cm_rlvl != '0) ? cm_rlvl : r_ocost;
    assign ro       = nb_row_off(r_k);
    assign co       = nb_col_off(r_k);

    assign o_in_stall   = (r_state != ST_IDLE);
    assign o_out_valid  = r_ovalid;
    assign o_reply_kind = r_okind;
    assign o_passable   = r_opas;
    assign o_extra_cost = r_ocost_out;
    assign pready       = 1'b1;

    // Grid size as it stands after this edge
    always_comb begin
        n_grid_rows = r_grid_rows;
        n_grid_cols = r_grid_cols;
        if (!i_rst_n) begin
            n_grid_rows = GRID_W'(64);
            n_grid_cols = GRID_W'(64);
        end else if (cfg_wr && paddr[3:2] == REG_ROWS) begin
            n_grid_rows = pwdata[GRID_W-1:0];
        end else if (cfg_wr && paddr[3:2] == REG_COLS) begin
            n_grid_cols = pwdata[GRID_W-1:0];
        end
    end

    // Clamp grid size
    assign rows_eff = (n_grid_rows == '0) ? RW'(1) :
                      (GRW'(n_grid_rows) > GRW'(MAX_ROWS)) ? RW'(MAX_ROWS) : RW'(n_grid_rows);
    assign cols_eff = (n_grid_cols == '0) ? CLW'(1) :
                      (GCW'(n_grid_cols) > GCW'(MAX_COLS)) ? CLW'(MAX_COLS) : CLW'(n_grid_cols);

    // Configuration write and read back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_W'(64);
            r_grid_cols <= GRID_W'(64);
            r_ocost     <= LVL_W'(10);
            r_hlim      <= 16'd50;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_ROWS:  r_grid_rows <= pwdata[GRID_W-1:0];
                REG_COLS:  r_grid_cols <= pwdata[GRID_W-1:0];
                REG_OCOST: r_ocost     <= pwdata[LVL_W-1:0];
                REG_HLIM:  r_hlim      <= pwdata[15:0];
                default:   r_hlim      <= r_hlim;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROWS:  prdata = 32'(r_grid_rows);
            REG_COLS:  prdata = 32'(r_grid_cols);
            REG_OCOST: prdata = 32'(r_ocost);
            REG_HLIM:  prdata = 32'(r_hlim);
            default:   prdata = '0;
        endcase
    end

    // Register effective size and cell count
    always_ff @(posedge i_clk) begin
        r_rows   <= rows_eff;
        r_cols   <= cols_eff;
        r_ncells <= CNTW'(CNTW'(rows_eff) * CNTW'(cols_eff));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_mode == MODE_RUN) begin
                    n_state = ST_H_CRD;
                end else if (in_acc && i_mode == MODE_READ) begin
                    n_state = ST_RD_EV;
                end
            end
            ST_RD_EV: begin
                if (out_free) n_state = ST_IDLE;
            end
            ST_H_CRD: begin
                n_state = (r_hr == r_rows) ? ST_S_SRD : ST_H_CEV;
            end
            ST_H_CEV: begin
                n_state = cm_rpas ? ST_H_NB : ST_H_CRD;
            end
            ST_H_NB: begin
                if (r_k == 4'd4) begin
                    n_state = ST_H_CRD;
                end else if (nb_ok) begin
                    n_state = ST_H_NEV;
                end
            end
            ST_H_NEV: begin
                if (cm_rpas && (hdiff > $signed({1'b0, r_hlim}))) begin
                    n_state = ST_H_CRD;
                end else begin
                    n_state = ST_H_NB;
                end
            end
            ST_S_SRD: begin
                n_state = (r_s == r_cnt) ? ST_DONE : ST_S_SGET;
            end
            ST_S_SGET: begin
                n_state = (XW'(sq_rdata) >= XW'(r_ncells)) ? ST_S_SRD : ST_S_DIV;
            end
            ST_S_DIV: begin
                if (r_rem < cols_x) n_state = ST_S_LEV;
            end
            ST_S_LEV: begin
                n_state = (base_lvl >= LVL_W'(MIN_RING + RING_STEP)) ? ST_F_FRD : ST_S_SRD;
            end
            ST_F_FRD: begin
                if (r_i != r_now) begin
                    n_state = ST_F_FGET;
                end else if (r_nxt == '0 || r_lvl < LVL_W'(MIN_RING + RING_STEP)) begin
                    n_state = ST_S_SRD;
                end
            end
            ST_F_FGET: n_state = ST_F_NB;
            ST_F_NB: begin
                if (r_k == 4'd8) begin
                    n_state = ST_F_FRD;
                end else if (nb_ok) begin
                    n_state = ST_F_NRD;
                end
            end
            ST_F_NRD: n_state = ST_F_NEV;
            ST_F_NEV: n_state = ST_F_NB;
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Neighbour bounds for the current step
    always_comb begin
        nb_ok = 1'b0;
        n_nr  = r_nr;
        n_nc  = r_nc;
        if (r_state == ST_H_NB) begin
            case (r_k)
                4'd0:    nb_ok = (r_hr != '0);
                4'd1:    nb_ok = ((r_hr + RW'(1)) < r_rows);
                4'd2:    nb_ok = (r_hc != '0);
                4'd3:    nb_ok = ((r_hc + CLW'(1)) < r_cols);
                default: nb_ok = 1'b0;
            endcase
        end else if (r_state == ST_F_NB && r_k != 4'd8) begin
            nb_ok = 1'b1;
            case (ro)
                OFF_NEG: begin
                    nb_ok = nb_ok && (r_fr != '0);
                    n_nr  = r_fr - RW'(1);
                end
                OFF_POS: begin
                    nb_ok = nb_ok && ((r_fr + RW'(1)) < r_rows);
                    n_nr  = r_fr + RW'(1);
                end
                default: n_nr = r_fr;
            endcase
            case (co)
                OFF_NEG: begin
                    nb_ok = nb_ok && (r_fc != '0);
                    n_nc  = r_fc - CLW'(1);
                end
                OFF_POS: begin
                    nb_ok = nb_ok && ((r_fc + CLW'(1)) < r_cols);
                    n_nc  = r_fc + CLW'(1);
                end
                default: n_nc = r_fc;
            endcase
        end
    end

    // Datapath and memory controls
    always_comb begin
        n_cnt       = r_cnt;
        n_s         = r_s;
        n_hidx      = r_hidx;
        n_hr        = r_hr;
        n_hc        = r_hc;
        n_k         = r_k;
        n_h0        = r_h0;
        n_seed      = r_seed;
        n_rem       = r_rem;
        n_fr        = r_fr;
        n_fc        = r_fc;
        n_naddr     = r_naddr;
        n_lvl       = r_lvl;
        n_now       = r_now;
        n_nxt       = r_nxt;
        n_i         = r_i;
        n_cur       = r_cur;
        n_oob       = r_oob;
        n_ovalid    = out_free ? 1'b0 : r_ovalid;
        n_okind     = r_okind;
        n_opas      = r_opas;
        n_ocost_out = r_ocost_out;

        cm_we    = '0;
        cm_waddr = r_hidx[AW-1:0];
        cm_wpas  = 1'b0;
        cm_whgt  = i_height;
        cm_wlvl  = '0;
        cm_re    = 1'b0;
        cm_raddr = r_hidx[AW-1:0];
        sq_we    = 1'b0;
        sq_waddr = r_cnt[AW-1:0];
        sq_wdata = r_hidx[AW-1:0];
        sq_re    = 1'b0;
        sq_raddr = r_s[AW-1:0];
        fq_we    = 1'b0;
        fq_waddr = {r_cur, AW'(0)};
        fq_wdata = {r_fr, r_fc};
        fq_re    = 1'b0;
        fq_raddr = {r_cur, r_i[AW-1:0]};

        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_mode == MODE_LOAD && idx_ok) begin
                    // Write one cell; obstacles keep their height
                    cm_waddr = AW'(i_cell_index);
                    if (i_obstacle_hit) begin
                        cm_we.pas = 1'b1;
                        cm_we.lvl = 1'b1;
                        cm_wlvl   = r_ocost;
                        if (r_cnt < CNTW'(CELLS)) begin
                            sq_we    = 1'b1;
                            sq_wdata = AW'(i_cell_index);
                            n_cnt    = r_cnt + CNTW'(1);
                        end
                    end else begin
                        cm_we   = '{pas: 1'b1, hgt: 1'b1, lvl: 1'b1};
                        cm_wpas = i_floor_hit;
                    end
                end else if (in_acc && i_mode == MODE_READ) begin
                    cm_re    = idx_ok;
                    cm_raddr = AW'(i_cell_index);
                    n_oob    = !idx_ok;
                end else if (in_acc && i_mode == MODE_RUN) begin
                    n_hidx = '0;
                    n_hr   = '0;
                    n_hc   = '0;
                end
            end
            ST_RD_EV: begin
                if (out_free) begin
                    n_ovalid    = 1'b1;
                    n_okind     = REPLY_READ;
                    n_opas      = r_oob ? 1'b0 : cm_rpas;
                    n_ocost_out = r_oob ? '0 :
                                  COST_W'(COST_W'(cm_rlvl) * COST_W'(COST_SCALE));
                end
            end
            ST_H_CRD: begin
                if (r_hr == r_rows) begin
                    n_s = '0;
                end else begin
                    cm_re = 1'b1;
                end
            end
            ST_H_CEV: begin
                n_h0 = cm_rhgt;
                n_k  = '0;
                if (!cm_rpas) begin
                    n_hidx = r_hidx + CNTW'(1);
                    if (r_hc + CLW'(1) == r_cols) begin
                        n_hc = '0;
                        n_hr = r_hr + RW'(1);
                    end else begin
                        n_hc = r_hc + CLW'(1);
                    end
                end
            end
            ST_H_NB: begin
                if (r_k == 4'd4) begin
                    n_hidx = r_hidx + CNTW'(1);
                    if (r_hc + CLW'(1) == r_cols) begin
                        n_hc = '0;
                        n_hr = r_hr + RW'(1);
                    end else begin
                        n_hc = r_hc + CLW'(1);
                    end
                end else if (nb_ok) begin
                    // Up, down, left, right
                    cm_re = 1'b1;
                    case (r_k)
                        4'd0:    cm_raddr = AW'(r_hidx - cols_x);
                        4'd1:    cm_raddr = AW'(r_hidx + cols_x);
                        4'd2:    cm_raddr = AW'(r_hidx - CNTW'(1));
                        default: cm_raddr = AW'(r_hidx + CNTW'(1));
                    endcase
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            ST_H_NEV: begin
                if (cm_rpas && (hdiff > $signed({1'b0, r_hlim}))) begin
                    cm_we.lvl = 1'b1;
                    cm_wlvl   = (r_ocost >= LVL_W'(RING_STEP)) ?
                                r_ocost - LVL_W'(RING_STEP) : '0;
                    if (r_cnt < CNTW'(CELLS)) begin
                        sq_we = 1'b1;
                        n_cnt = r_cnt + CNTW'(1);
                    end
                    n_hidx = r_hidx + CNTW'(1);
                    if (r_hc + CLW'(1) == r_cols) begin
                        n_hc = '0;
                        n_hr = r_hr + RW'(1);
                    end else begin
                        n_hc = r_hc + CLW'(1);
                    end
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            ST_S_SRD: begin
                if (r_s == r_cnt) begin
                    n_cnt = '0;
                end else begin
                    sq_re = 1'b1;
                end
            end
            ST_S_SGET: begin
                n_s    = r_s + CNTW'(1);
                n_seed = sq_rdata;
                n_rem  = CNTW'(sq_rdata);
                n_fr   = '0;
            end
            ST_S_DIV: begin
                // Row by repeated subtraction, remainder is the column
                if (r_rem >= cols_x) begin
                    n_rem = r_rem - cols_x;
                    n_fr  = r_fr + RW'(1);
                end else begin
                    n_fc     = CLW'(r_rem);
                    cm_re    = 1'b1;
                    cm_raddr = r_seed;
                end
            end
            ST_S_LEV: begin
                if (base_lvl >= LVL_W'(MIN_RING + RING_STEP)) begin
                    n_lvl = base_lvl - LVL_W'(RING_STEP);
                    fq_we = 1'b1;
                    n_now = CNTW'(1);
                    n_nxt = '0;
                    n_i   = '0;
                end
            end
            ST_F_FRD: begin
                if (r_i != r_now) begin
                    fq_re = 1'b1;
                end else if (r_nxt != '0 && r_lvl >= LVL_W'(MIN_RING + RING_STEP)) begin
                    // Advance to the next ring
                    n_lvl = r_lvl - LVL_W'(RING_STEP);
                    n_now = r_nxt;
                    n_nxt = '0;
                    n_i   = '0;
                    n_cur = !r_cur;
                end
            end
            ST_F_FGET: begin
                n_fr = fq_rdata[FW-1:CLW];
                n_fc = fq_rdata[CLW-1:0];
                n_i  = r_i + CNTW'(1);
                n_k  = '0;
            end
            ST_F_NB: begin
                if (r_k != 4'd8) begin
                    n_k = r_k + 4'd1;
                end
            end
            ST_F_NRD: begin
                cm_re    = 1'b1;
                cm_raddr = AW'(AW'(r_nr) * AW'(r_cols)) + AW'(r_nc);
                n_naddr  = cm_raddr;
            end
            ST_F_NEV: begin
                if (cm_rlvl < r_lvl) begin
                    cm_we.lvl = 1'b1;
                    cm_waddr  = r_naddr;
                    cm_wlvl   = r_lvl;
                    if (r_nxt < CNTW'(CELLS)) begin
                        fq_we    = 1'b1;
                        fq_waddr = {!r_cur, r_nxt[AW-1:0]};
                        fq_wdata = {r_nr, r_nc};
                        n_nxt    = r_nxt + CNTW'(1);
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ovalid    = 1'b1;
                    n_okind     = REPLY_DONE;
                    n_opas      = 1'b0;
                    n_ocost_out = '0;
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_nxt    <= '0;
            r_ovalid <= 1'b0;
            r_cur    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_nxt    <= n_nxt;
            r_ovalid <= n_ovalid;
            r_cur    <= n_cur;
        end
    end

    // Work registers
    always_ff @(posedge i_clk) begin
        r_s         <= n_s;
        r_hidx      <= n_hidx;
        r_hr        <= n_hr;
        r_hc        <= n_hc;
        r_k         <= n_k;
        r_h0        <= n_h0;
        r_seed      <= n_seed;
        r_rem       <= n_rem;
        r_fr        <= n_fr;
        r_fc        <= n_fc;
        r_nr        <= n_nr;
        r_nc        <= n_nc;
        r_naddr     <= n_naddr;
        r_lvl       <= n_lvl;
        r_now       <= n_now;
        r_i         <= n_i;
        r_oob       <= n_oob;
        r_okind     <= n_okind;
        r_opas      <= n_opas;
        r_ocost_out <= n_ocost_out;
    end

    // Seed queue memory
    always_ff @(posedge i_clk) begin
        if (sq_we) begin
            seed_mem[sq_waddr] <= sq_wdata;
        end
        if (sq_re) begin
            sq_rdata <= seed_mem[sq_raddr];
        end
    end

    // Frontier memory, two halves swapped per ring
    always_ff @(posedge i_clk) begin
        if (fq_we) begin
            front_mem[fq_waddr] <= fq_wdata;
        end
        if (fq_re) begin
            fq_rdata <= front_mem[fq_raddr];
        end
    end

    gcmi_cell_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_cell_mem (
        .i_clk   (i_clk),
        .i_we    (cm_we),
        .i_waddr (cm_waddr),
        .i_wpas  (cm_wpas),
        .i_whgt  (cm_whgt),
        .i_wlvl  (cm_wlvl),
        .i_re    (cm_re),
        .i_raddr (cm_raddr),
        .o_rpas  (cm_rpas),
        .o_rhgt  (cm_rhgt),
        .o_rlvl  (cm_rlvl)
    );

`ifndef ASSERT_OFF
    a_ring_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_F_NB || r_state == ST_F_NRD || r_state == ST_F_NEV)
        |-> (r_lvl >= LVL_W'(MIN_RING)))
        else $error("flood ring below minimum level");

    a_frontier_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nxt <= CNTW'(CELLS)) && (r_cnt <= CNTW'(CELLS)))
        else $error("queue count beyond capacity");

    a_hpass_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_H_CEV) |-> (r_hr < r_rows) && (r_hc < r_cols))
        else $error("height pass outside grid");

    a_seed_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> (r_cnt == '0))
        else $error("seed queue not emptied at run end");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ovalid) |-> $past(!i_out_stall))
        else $error("result word lost under stall");
`endif

endmodule

`default_nettype wire

FILE: hdl/gcmi_cell_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module gcmi_cell_mem
    import gcmi_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic             i_clk,
    input  wire t_cell_we         i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic             i_wpas,
    input  wire logic [HGT_W-1:0] i_whgt,
    input  wire logic [LVL_W-1:0] i_wlvl,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic                  o_rpas,
    output logic [HGT_W-1:0]      o_rhgt,
    output logic [LVL_W-1:0]      o_rlvl
);

    logic             pas_mem [DEPTH];
    logic [HGT_W-1:0] hgt_mem [DEPTH];
    logic [LVL_W-1:0] lvl_mem [DEPTH];

    // Write each field under its own enable
    always_ff @(posedge i_clk) begin
        if (i_we.pas) begin
            pas_mem[i_waddr] <= i_wpas;
        end
        if (i_we.hgt) begin
            hgt_mem[i_waddr] <= i_whgt;
        end
        if (i_we.lvl) begin
            lvl_mem[i_waddr] <= i_wlvl;
        end
    end

    // Registered read, held while idle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rpas <= pas_mem[i_raddr];
            o_rhgt <= hgt_mem[i_raddr];
            o_rlvl <= lvl_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
